@@ hw/rtl/double_ended_queue_macros.svh @@
// Assertion macros shared by the double-ended queue RTL.
// Depends on nothing; a file using them must have clk and rst in scope.
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DQ_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("double_ended_queue: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define DQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("double_ended_queue: next-cycle check failed");

`endif

@@ hw/rtl/deq_pkg.sv @@
// Types and codes for the double-ended queue.
// Used by deq_cell and double_ended_queue; depends on nothing.
package deq_pkg;

  typedef logic signed [31:0] elem_t;

  // Action codes of an input item.
  localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [2:0] ACT_POP_BACK   = 3'd3;
  localparam logic [2:0] ACT_DUMP       = 3'd4;

  // Status codes of a result item.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // What every cell of the chain does in a cycle.
  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_SHIFT_IN,   // take the left neighbour; cell 0 takes the pushed value
    CMD_LOAD_BACK,  // the cell at the fill level takes the pushed value
    CMD_SHIFT_OUT,  // take the right neighbour
    CMD_ROTATE      // shift out, the last held cell takes the head
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t cmd;
    elem_t     value;
  } cell_ctl_t;

endpackage

@@ hw/rtl/deq_cell.sv @@
// One storage cell of the double-ended queue chain.
// Depends on deq_pkg.
module deq_cell import deq_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int INDEX = 0
) (
  input  logic                         clk,
  input  cell_ctl_t                    ctl,
  input  logic [$clog2(DEPTH+1)-1:0]   count,
  input  elem_t                        left_data,
  input  elem_t                        right_data,
  input  elem_t                        head_data,
  output elem_t                        data
);

  localparam int CW = $clog2(DEPTH + 1);

  always_ff @(posedge clk) begin
    case (ctl.cmd)
      CMD_SHIFT_IN:  data <= left_data;
      CMD_SHIFT_OUT: data <= right_data;
      CMD_LOAD_BACK: begin
        if (count == CW'(INDEX)) data <= ctl.value;
      end
      CMD_ROTATE: begin
        if (count == CW'(INDEX + 1)) data <= head_data;
        else data <= right_data;
      end
      default: data <= data;
    endcase
  end

endmodule

@@ hw/rtl/double_ended_queue.sv @@
// Top level of the double-ended queue: control, fill count and the cell chain.
// Depends on deq_pkg, deq_cell and double_ended_queue_macros.svh.
//
//   Channel | Handshake           | Payload
//   --------+---------------------+---------------------------
//   input   | start, busy         | action, value
//   result  | strobe (one cycle)  | status, element, last
//
// A push or a pop is taken at once and its single result appears on the
// cycle after; busy stays low, so such items may follow back to back.
// A dump of n held entries raises busy and gives n results, one result per cycle,
// as the chain rotates each entry past cell 0; an empty dump gives one empty result.
// The synchronous reset empties the queue; cell contents are not cleared.
// Results cannot be stalled: the receiver must take each one as it appears.
`include "double_ended_queue_macros.svh"

module double_ended_queue import deq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         action,
  input  logic signed [31:0] value,
  output logic               strobe,
  output logic [1:0]         status,
  output logic signed [31:0] element,
  output logic               last
);

  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DUMP = 2'b10
  } state_t;

  state_t         state;
  logic [CW-1:0]  count;
  logic [CW-1:0]  remaining;
  cell_ctl_t      ctl;
  elem_t          cell_data [DEPTH];
  logic           accept;
  logic           is_full;
  logic           is_empty;

  assign busy     = (state == S_DUMP);
  assign accept   = start && !busy;
  assign is_full  = (count == CW'(DEPTH));
  assign is_empty = (count == '0);

  // The command that the whole chain carries out this cycle.
  always_comb begin
    ctl.cmd   = CMD_HOLD;
    ctl.value = value;
    if (busy) begin
      ctl.cmd = CMD_ROTATE;
    end else if (accept) begin
      case (action)
        ACT_PUSH_FRONT: if (!is_full) ctl.cmd = CMD_SHIFT_IN;
        ACT_PUSH_BACK:  if (!is_full) ctl.cmd = CMD_LOAD_BACK;
        ACT_POP_FRONT:  if (!is_empty) ctl.cmd = CMD_SHIFT_OUT;
        default:        ctl.cmd = CMD_HOLD;
      endcase
    end
  end

  // The chain: cell 0 holds the front; the back sits at cell count-1.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    elem_t left_in;
    elem_t right_in;
    if (i == 0) begin : g_first
      assign left_in = value;
    end else begin : g_mid_l
      assign left_in = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_end
      assign right_in = '0;
    end else begin : g_mid_r
      assign right_in = cell_data[i+1];
    end
    deq_cell #(
      .DEPTH (DEPTH),
      .INDEX (i)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .count      (count),
      .left_data  (left_in),
      .right_data (right_in),
      .head_data  (cell_data[0]),
      .data       (cell_data[i])
    );
  end

  // Control state and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (action)
              ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
                strobe <= 1'b1;
                if (!is_full) count <= count + CW'(1);
              end
              ACT_POP_FRONT, ACT_POP_BACK: begin
                strobe <= 1'b1;
                if (!is_empty) count <= count - CW'(1);
              end
              ACT_DUMP: begin
                if (is_empty) strobe <= 1'b1;
                else state <= S_DUMP;
              end
              default: ;
            endcase
          end
        end
        S_DUMP: begin
          strobe <= 1'b1;
          if (remaining == CW'(1)) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result payload and the dump counter need no reset.
  always_ff @(posedge clk) begin
    if (busy) begin
      status    <= ST_OK;
      element   <= cell_data[0];
      last      <= (remaining == CW'(1));
      remaining <= remaining - CW'(1);
    end else if (accept) begin
      element   <= '0;
      last      <= 1'b1;
      remaining <= count;
      case (action)
        ACT_PUSH_FRONT, ACT_PUSH_BACK: status <= is_full ? ST_FULL : ST_OK;
        ACT_POP_FRONT, ACT_POP_BACK:   status <= is_empty ? ST_EMPTY : ST_OK;
        default:                       status <= ST_EMPTY;
      endcase
    end
  end

  `DQ_ASSERT_SAME(a_count_bound, 1'b1, count <= CW'(DEPTH))
  `DQ_ASSERT_NEXT(a_full_push, accept && is_full && action == ACT_PUSH_BACK,
                  strobe && status == ST_FULL && last)
  `DQ_ASSERT_SAME(a_more_follow, strobe && !last, busy)
  `DQ_ASSERT_NEXT(a_dump_busy, accept && !is_empty && action == ACT_DUMP, busy)

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for double_ended_queue: a predictor and result checker
// in a small scoreboard class, with plain tasks for stimulus and idling.
// Depends on deq_pkg and the double_ended_queue RTL.
module tb;
  import deq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16;
  // Cycles without an item taken that are tolerated before giving up.
  // A legal run never goes nearly that long without taking one.
  localparam int QUIET_LIMIT = 2000;
  localparam int ITEMS_PER_PHASE = 50;

  // Predicts the queue contents and the results owed for every item taken,
  // then matches each strobed result against the oldest one owed.
  class deque_scoreboard #(int CAP = 16);
    typedef struct {
      logic [1:0] status;
      elem_t      element;
      logic       last;
    } answer_t;

    elem_t   held[$];   // predicted contents, front of queue first
    answer_t owed[$];   // results still to arrive, oldest first
    int      errors = 0;
    int      taken = 0;
    int      ignored = 0;
    int      checked = 0;
    int      dumps = 0;
    int      full_hits = 0;
    int      empty_hits = 0;

    function void owe(logic [1:0] st, elem_t el, logic lst);
      answer_t a;
      a.status = st;
      a.element = el;
      a.last = lst;
      owed.push_back(a);
    endfunction

    // Called for every item the block takes.
    function void note_item(logic [2:0] act, elem_t val);
      taken++;
      case (act)
        ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
          if (held.size() >= CAP) begin
            full_hits++;
            owe(ST_FULL, '0, 1'b1);
          end else begin
            if (act == ACT_PUSH_FRONT) held.push_front(val);
            else held.push_back(val);
            owe(ST_OK, '0, 1'b1);
          end
        end
        ACT_POP_FRONT, ACT_POP_BACK: begin
          if (held.size() == 0) begin
            empty_hits++;
            owe(ST_EMPTY, '0, 1'b1);
          end else begin
            if (act == ACT_POP_FRONT) void'(held.pop_front());
            else void'(held.pop_back());
            owe(ST_OK, '0, 1'b1);
          end
        end
        ACT_DUMP: begin
          dumps++;
          if (held.size() == 0) begin
            empty_hits++;
            owe(ST_EMPTY, '0, 1'b1);
          end else begin
            foreach (held[k]) owe(ST_OK, held[k], k == held.size() - 1);
          end
        end
        default: ignored++;  // unused codes: no result and no change
      endcase
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task check_result(logic [1:0] st, elem_t el, logic lst);
      answer_t a;
      if (owed.size() == 0) begin
        report($sformatf("unexpected result status=%0d element=%0d last=%0d", st, el, lst));
      end else begin
        a = owed.pop_front();
        checked++;
        if (st !== a.status || el !== a.element || lst !== a.last) begin
          report($sformatf("got status=%0d element=%0d last=%0d, wanted %0d/%0d/%0d",
                           st, el, lst, a.status, a.element, a.last));
        end
      end
    endtask

    task check_leftovers();
      while (owed.size() != 0) begin
        void'(owed.pop_front());
        report("a result owed to an accepted item never arrived");
      end
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst;
  logic               start;
  logic               busy;
  logic [2:0]         action;
  logic signed [31:0] value;
  logic               strobe;
  logic [1:0]         status;
  logic signed [31:0] element;
  logic               last;

  deque_scoreboard #(DEPTH) sb;
  int idle_pct = 0;   // chance in a hundred that the sender idles instead of sending
  int sent = 0;       // items with a real action code handed over
  int quiet = 0;

  double_ended_queue #(.DEPTH(DEPTH)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action), .value(value),
    .strobe(strobe), .status(status), .element(element), .last(last)
  );

  always #10 clk = ~clk;

  // Everything is observed at the rising edge. The result is checked before the
  // item of the same edge is noted; a push or pop answers in the cycle after, so
  // the order never matters, but it keeps the queue of owed results honest.
  always @(posedge clk) begin
    if (!rst) begin
      if (strobe) sb.check_result(status, element, last);
      if (start && !busy) sb.note_item(action, value);
    end
  end

  // Watchdog: the run is declared hung after a long stretch in which no item
  // is taken, so a block stuck in a dump cannot keep the run alive.
  always @(posedge clk) begin
    if (rst || (start && !busy)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet + 1 >= QUIET_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", QUIET_LIMIT);
        $display("double_ended_queue regression: fail");
        $finish;
      end
    end
  end

  // Hands one item to the block. Called at a falling edge and returns at a
  // falling edge once the item has been taken. Before the item the sender may
  // sit idle for a random number of cycles, which lands gaps between back-to-back
  // pushes and pops; idle cycles may overlap a dump but never break it up.
  task automatic issue(input logic [2:0] act, input elem_t val);
    while ($urandom_range(99) < idle_pct) begin
      start  <= 1'b0;
      action <= 3'($urandom);
      value  <= $urandom;
      @(negedge clk);
    end
    start  <= 1'b1;
    action <= act;
    value  <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    if (act <= ACT_DUMP) sent++;
  endtask

  // Mostly ordinary numbers, with the corners of the signed range mixed in.
  function automatic elem_t pick_value();
    case ($urandom_range(15))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] either_end(logic [2:0] front_code, logic [2:0] back_code);
    return $urandom_range(1) ? front_code : back_code;
  endfunction

  // Pushes past the capacity so that the last pushes are refused, then lists
  // the full store.
  task automatic fill_up();
    repeat (DEPTH + 2) issue(either_end(ACT_PUSH_FRONT, ACT_PUSH_BACK), pick_value());
    issue(ACT_DUMP, pick_value());
  endtask

  // Pops past empty so that the last pops are refused, then dumps the empty store.
  task automatic drain();
    repeat (DEPTH + 2) issue(either_end(ACT_POP_FRONT, ACT_POP_BACK), pick_value());
    issue(ACT_DUMP, pick_value());
  endtask

  // A short run of mixed actions with a little noise from the unused codes.
  task automatic mixed_run();
    int pick;
    repeat ($urandom_range(1, 8)) begin
      pick = $urandom_range(99);
      if (pick < 40)      issue(either_end(ACT_PUSH_FRONT, ACT_PUSH_BACK), pick_value());
      else if (pick < 75) issue(either_end(ACT_POP_FRONT, ACT_POP_BACK), pick_value());
      else if (pick < 90) issue(ACT_DUMP, pick_value());
      else                issue(3'($urandom_range(5, 7)), pick_value());
    end
  endtask

  initial begin
    int phase_idle[4];
    sb = new();
    phase_idle = '{0, 51, 0, 17};
    rst    = 1'b1;
    start  = 1'b0;
    action = ACT_PUSH_FRONT;
    value  = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part: refusals on an empty store, the unused codes, the
    // extremes of the value range at both ends, and dumps at several fills.
    issue(ACT_DUMP, 32'sh1234_5678);
    issue(ACT_POP_FRONT, '0);
    issue(ACT_POP_BACK, '1);
    issue(3'd5, 32'sh5555_5555);
    issue(3'd6, 32'shaaaa_aaaa);
    issue(3'd7, '1);
    issue(ACT_PUSH_FRONT, 32'sh7fff_ffff);
    issue(ACT_PUSH_BACK, 32'sh8000_0000);
    issue(ACT_PUSH_FRONT, '0);
    issue(ACT_PUSH_BACK, '1);
    issue(ACT_DUMP, '0);
    issue(ACT_POP_FRONT, '0);
    issue(ACT_DUMP, '0);
    issue(ACT_POP_BACK, '0);
    issue(ACT_DUMP, '0);
    issue(ACT_POP_BACK, '0);
    issue(ACT_POP_FRONT, '0);
    issue(ACT_POP_FRONT, '0);
    issue(ACT_DUMP, '0);

    // Random part, in phases of differing sender idling. Whole fills and
    // drains carry the queue through full and empty, and the shorter mixed
    // runs stir the middle.
    fill_up();
    drain();
    foreach (phase_idle[p]) begin
      idle_pct = phase_idle[p];
      while (sent < 25 + (p + 1) * ITEMS_PER_PHASE) begin
        case ($urandom_range(9))
          0, 1:    fill_up();
          2, 3:    drain();
          default: mixed_run();
        endcase
      end
    end
    start <= 1'b0;

    // Let the owed results drain, then allow a dump's worth of further cycles
    // so that any stray result would still be caught.
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (DEPTH + 4) @(posedge clk);
    sb.check_leftovers();

    $display("covered %0d items taken (%0d with unused codes), %0d results checked",
             sb.taken, sb.ignored, sb.checked);
    $display("dumps %0d, refused pushes on a full store %0d, empty answers %0d",
             sb.dumps, sb.full_hits, sb.empty_hits);
    if (sb.errors == 0) begin
      $display("double_ended_queue regression: pass");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("double_ended_queue regression: fail");
    end
    $finish;
  end

endmodule
